/* design/rxbd_pkg.sv */
// ----------------------------------------------------------------------------
// rxbd_pkg
// Shared types, codes and sizes for the receive byte destuff FIFO.
// ----------------------------------------------------------------------------
package rxbd_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = 7;
	localparam int ENTRY_W     = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_PEEK = 2'd1;
	localparam logic [1:0] ACT_POP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CHAR = 2'd1;

	localparam logic [7:0] ESC_OCTET    = 8'h7D;
	localparam logic [7:0] INVERT_OCTET = 8'h20;
	localparam logic [7:0] FLAG_OCTET   = 8'h7E;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ESC   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_NOP  = 3'd0,
		CMD_ESC  = 3'd1,
		CMD_PUSH = 3'd2,
		CMD_PEEK = 3'd3,
		CMD_POP  = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [CNT_W-1:0]   queue_count;
		logic [ENTRY_W-1:0] head_entry;
		logic               head_valid;
		logic               head_is_sync;
		logic [ENTRY_W-1:0] latched_data;
		logic [15:0]        overrun_count;
		logic [ENTRY_W-1:0] last_received;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ENTRY_W-1:0] entry;
		logic [ENTRY_W-1:0] last;
	} cmd_t;

endpackage

/* design/rxbd_front.sv */
// ----------------------------------------------------------------------------
// rxbd_front
// Accepts input items, destuffs escaped bytes and classifies each action.
// ----------------------------------------------------------------------------
module rxbd_front
	import rxbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     cmd_push,
	output cmd_t     cmd
);

	logic               escape_q;
	logic [ENTRY_W-1:0] last_q;
	logic [ENTRY_W-1:0] decoded;
	logic               take;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign cmd_push = take;
	assign decoded  = escape_q ? {1'b1, in_data.rx_byte ^ INVERT_OCTET}
	                           : {1'b0, in_data.rx_byte};

	always_comb begin
		cmd.entry = decoded;
		cmd.last  = last_q;
		case (in_data.action)
			ACT_PUSH: begin
				if (in_data.rx_byte == ESC_OCTET) begin
					cmd.kind = CMD_ESC;
				end else begin
					cmd.kind = CMD_PUSH;
					cmd.last = decoded;
				end
			end
			ACT_PEEK: cmd.kind = CMD_PEEK;
			ACT_POP:  cmd.kind = CMD_POP;
			default:  cmd.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			last_q   <= '0;
		end else if (take && in_data.action == ACT_PUSH) begin
			if (in_data.rx_byte == ESC_OCTET) begin
				escape_q <= 1'b1;
			end else begin
				escape_q <= 1'b0;
				last_q   <= decoded;
			end
		end
	end

endmodule

/* design/rxbd_cmdq.sv */
// ----------------------------------------------------------------------------
// rxbd_cmdq
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module rxbd_cmdq
	import rxbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_cmd   = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/rxbd_back.sv */
// ----------------------------------------------------------------------------
// rxbd_back
// Executes queued commands on the entry FIFO and forms the result item.
// ----------------------------------------------------------------------------
module rxbd_back
	import rxbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_pop,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	typedef enum logic [2:0] {
		B_EXEC = 3'b001,
		B_READ = 3'b010,
		B_FORM = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [15:0]        ovr_q;
	logic [ENTRY_W-1:0] peeked_q;
	logic [ENTRY_W-1:0] last_q;
	status_t            status_q;
	logic               peek_ok_q;
	logic               mode_q;
	logic [7:0]         sync_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               exec;
	logic               has_room;
	logic               not_empty;
	logic               wr_en;
	logic               out_free;
	logic               form;
	logic [ENTRY_W-1:0] head;
	logic               head_ok;
	out_item_t          result;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign exec      = (state_q == B_EXEC) && cmd_valid;
	assign cmd_pop   = exec;
	assign has_room  = cnt_q < CNT_W'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign wr_en     = exec && cmd.kind == CMD_PUSH && has_room;
	assign out_free  = !out_valid_q || !out_stall;
	assign form      = (state_q == B_FORM) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= cmd.entry;
		end
		if (state_q == B_READ) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_comb begin
		head_ok              = not_empty;
		head                 = head_ok ? rd_data_q : '0;
		result.status        = status_q;
		result.queue_count   = cnt_q;
		result.head_entry    = head;
		result.head_valid    = head_ok;
		result.head_is_sync  = head_ok && !head[8] &&
		                       (head[7:0] == FLAG_OCTET || (mode_q && head[7:0] == sync_q));
		result.latched_data  = peek_ok_q ? rd_data_q : peeked_q;
		result.overrun_count = ovr_q;
		result.last_received = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			sync_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BYTE_MODE: mode_q <= cfg_data[0];
				CFG_SYNC_CHAR: sync_q <= cfg_data;
				default:       mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_EXEC;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			ovr_q       <= '0;
			peeked_q    <= '0;
			last_q      <= '0;
			status_q    <= ST_OK;
			peek_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_EXEC: begin
					if (exec) begin
						state_q <= B_READ;
						last_q  <= cmd.last;
						case (cmd.kind)
							CMD_ESC: begin
								status_q  <= ST_ESC;
								peek_ok_q <= 1'b0;
							end
							CMD_PUSH: begin
								peek_ok_q <= 1'b0;
								if (has_room) begin
									wr_ptr_q <= next_ptr(wr_ptr_q);
									cnt_q    <= cnt_q + CNT_W'(1);
									status_q <= ST_OK;
								end else begin
									status_q <= ST_FULL;
								end
							end
							CMD_PEEK: begin
								if (not_empty) begin
									ovr_q     <= '0;
									peek_ok_q <= 1'b1;
									status_q  <= ST_OK;
								end else begin
									status_q  <= ST_EMPTY;
									peek_ok_q <= 1'b0;
									if (ovr_q != 16'hFFFF) begin
										ovr_q <= ovr_q + 16'd1;
									end
								end
							end
							CMD_POP: begin
								peek_ok_q <= 1'b0;
								if (not_empty) begin
									rd_ptr_q <= next_ptr(rd_ptr_q);
									cnt_q    <= cnt_q - CNT_W'(1);
									status_q <= ST_OK;
								end else begin
									status_q <= ST_EMPTY;
								end
							end
							default: begin
								status_q  <= ST_OK;
								peek_ok_q <= 1'b0;
							end
						endcase
					end
				end
				B_READ: state_q <= B_FORM;
				B_FORM: begin
					if (out_free) begin
						state_q <= B_EXEC;
					end
				end
				default: state_q <= B_EXEC;
			endcase

			if (form) begin
				out_valid_q <= 1'b1;
				if (peek_ok_q) begin
					peeked_q <= rd_data_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (form) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q == wr_ptr_q) == (cnt_q == '0 || cnt_q == CNT_W'(QUEUE_DEPTH)))
		else $error("pointers disagree with entry count");

	a_form_out: assert property (@(posedge clk) disable iff (!arst_n)
		form |=> out_valid_q)
		else $error("formed result not presented");

	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == B_READ)
		else $error("command taken without read step");
`endif

endmodule

/* design/rx_byte_destuff_fifo.sv */
// ----------------------------------------------------------------------------
// rx_byte_destuff_fifo
// Receive byte destuffing with a bounded entry FIFO and peek/pop access.
// ----------------------------------------------------------------------------
// Sequencing: the back sequencer finishes each command before it takes the next
//   (execute, registered memory read, result form); a stalled output holds it.
// Reset: arst_n clears pointers, counters, flags and config registers;
//   the entry memory is not cleared and needs no clearing pass.
module rx_byte_destuff_fifo
	import rxbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic q_full;
	logic cmd_push;
	cmd_t cmd_in;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	rxbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	rxbd_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	rxbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.cfg_valid (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
